// ===== hdl/pcs_pkg.sv =====
// shared types and constants for the packing cycle sequencer
package pcs_pkg;

  // command bytes
  localparam logic [7:0] CMD_START = 8'hFF;
  localparam logic [7:0] CMD_STOP  = 8'hFE;

  // configuration register indexes
  localparam logic [2:0] REG_VERT_DWELL  = 3'd0;
  localparam logic [2:0] REG_VERT_OPEN   = 3'd1;
  localparam logic [2:0] REG_HORIZ_DWELL = 3'd2;
  localparam logic [2:0] REG_HORIZ_OPEN  = 3'd3;
  localparam logic [2:0] REG_FILM_PULSES = 3'd4;
  localparam logic [2:0] REG_POLL_PERIOD = 3'd5;
  localparam logic [2:0] REG_PULSE_HALF  = 3'd6;

  // configuration reset values
  localparam logic [15:0] VERT_DWELL_RST  = 16'd300;
  localparam logic [15:0] VERT_OPEN_RST   = 16'd800;
  localparam logic [15:0] HORIZ_DWELL_RST = 16'd800;
  localparam logic [15:0] HORIZ_OPEN_RST  = 16'd2250;
  localparam logic [15:0] FILM_PULSES_RST = 16'd1200;
  localparam logic [7:0]  POLL_PERIOD_RST = 8'd50;
  localparam logic [7:0]  PULSE_HALF_RST  = 8'd2;

  // sub steps inside a seal phase; film pull uses the first two as pulse high and low
  localparam logic [1:0] SUB_CLOSE = 2'd0;
  localparam logic [1:0] SUB_DWELL = 2'd1;
  localparam logic [1:0] SUB_OPEN  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_VERT  = 3'd1,
    PH_FILM  = 3'd2,
    PH_CONV  = 3'd3,
    PH_HORIZ = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DRV_STOP  = 2'd0,
    DRV_CLOSE = 2'd1,
    DRV_OPEN  = 2'd2
  } drive_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic       vert_left_limit;
    logic       vert_right_limit;
    logic       horiz_limit;
    logic       object_seen;
  } in_beat_t;

  typedef struct packed {
    logic        running;
    logic [2:0]  phase;
    logic [1:0]  vert_left_drive;
    logic [1:0]  vert_right_drive;
    logic [1:0]  horiz_drive;
    logic        conveyor_on;
    logic [7:0]  conveyor_speed;
    logic        stepper_pulse;
    logic [31:0] product_count;
  } out_beat_t;

endpackage

// ===== hdl/packing_cycle_sequencer_core.sv =====
// packing cycle sequencer: command decode, cycle sequencing and result register
// latency: a result beat is registered and valid in the cycle after its input beat is accepted
// throughput: one input beat per cycle while out_ready drains the result; set by the single next-state stage
// input is taken whenever the result register is empty or being drained
// reset (rst, synchronous): stopped, idle, motors off, count zero, registers at defaults
module packing_cycle_sequencer_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pcs_pkg::in_beat_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pcs_pkg::out_beat_t    out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  // configuration registers
  logic [15:0] vert_dwell, vert_open, horiz_dwell, horiz_open, film_pulses;
  logic [7:0]  poll_period, pulse_half;

  // sequencer state
  logic            run_flag, empty_flag, empty_mark;
  pcs_pkg::phase_t phase;
  logic [1:0]      sub_step;
  logic [15:0]     ms_timer, pulse_counter;
  logic            left_done, right_done;
  logic [7:0]      speed;
  logic [31:0]     count;
  pcs_pkg::drive_t left_drv, right_drv, horiz_drv;
  logic            conv_on, pulse;

  logic            run_flag_next, empty_flag_next, empty_mark_next;
  pcs_pkg::phase_t phase_next;
  logic [1:0]      sub_step_next;
  logic [15:0]     ms_timer_next, pulse_counter_next;
  logic            left_done_next, right_done_next;
  logic [7:0]      speed_next;
  logic [31:0]     count_next;
  pcs_pkg::drive_t left_drv_next, right_drv_next, horiz_drv_next;
  logic            conv_on_next, pulse_next;

  logic [15:0] timer_limit, timer_inc, pc_inc;
  logic        timer_hit, in_take;
  logic        go_start, go_film, go_conv, go_horiz;
  pcs_pkg::out_beat_t result;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_take   = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vert_dwell  <= pcs_pkg::VERT_DWELL_RST;
      vert_open   <= pcs_pkg::VERT_OPEN_RST;
      horiz_dwell <= pcs_pkg::HORIZ_DWELL_RST;
      horiz_open  <= pcs_pkg::HORIZ_OPEN_RST;
      film_pulses <= pcs_pkg::FILM_PULSES_RST;
      poll_period <= pcs_pkg::POLL_PERIOD_RST;
      pulse_half  <= pcs_pkg::PULSE_HALF_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcs_pkg::REG_VERT_DWELL:  vert_dwell  <= cfg_data;
        pcs_pkg::REG_VERT_OPEN:   vert_open   <= cfg_data;
        pcs_pkg::REG_HORIZ_DWELL: horiz_dwell <= cfg_data;
        pcs_pkg::REG_HORIZ_OPEN:  horiz_open  <= cfg_data;
        pcs_pkg::REG_FILM_PULSES: film_pulses <= cfg_data;
        pcs_pkg::REG_POLL_PERIOD: poll_period <= cfg_data[7:0];
        pcs_pkg::REG_PULSE_HALF:  pulse_half  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // one shared millisecond timer: limit select, saturating increment, compare
  always_comb begin
    case (phase)
      pcs_pkg::PH_VERT: begin
        if (sub_step == pcs_pkg::SUB_CLOSE)      timer_limit = {8'd0, poll_period};
        else if (sub_step == pcs_pkg::SUB_DWELL) timer_limit = vert_dwell;
        else                                     timer_limit = vert_open;
      end
      pcs_pkg::PH_FILM: timer_limit = {8'd0, pulse_half};
      pcs_pkg::PH_HORIZ: begin
        if (sub_step == pcs_pkg::SUB_CLOSE)      timer_limit = {8'd0, poll_period};
        else if (sub_step == pcs_pkg::SUB_DWELL) timer_limit = horiz_dwell;
        else                                     timer_limit = horiz_open;
      end
      default: timer_limit = {8'd0, poll_period};
    endcase
  end

  assign timer_inc = (ms_timer != 16'hFFFF) ? ms_timer + 16'd1 : ms_timer;
  assign timer_hit = timer_inc >= timer_limit;
  assign pc_inc    = pulse_counter + 16'd1;

  // next state for one beat
  always_comb begin
    run_flag_next      = run_flag;
    empty_flag_next    = empty_flag;
    empty_mark_next    = empty_mark;
    phase_next         = phase;
    sub_step_next      = sub_step;
    ms_timer_next      = ms_timer;
    pulse_counter_next = pulse_counter;
    left_done_next     = left_done;
    right_done_next    = right_done;
    speed_next         = speed;
    count_next         = count;
    left_drv_next      = left_drv;
    right_drv_next     = right_drv;
    horiz_drv_next     = horiz_drv;
    conv_on_next       = conv_on;
    pulse_next         = pulse;
    go_start           = 1'b0;
    go_film            = 1'b0;
    go_conv            = 1'b0;
    go_horiz           = 1'b0;

    if (in_data.action) begin
      // command byte
      if (in_data.rx_byte == pcs_pkg::CMD_START) begin
        run_flag_next   = 1'b1;
        empty_flag_next = 1'b1;
      end else if (in_data.rx_byte == pcs_pkg::CMD_STOP) begin
        run_flag_next      = 1'b0;
        left_drv_next      = pcs_pkg::DRV_STOP;
        right_drv_next     = pcs_pkg::DRV_STOP;
        horiz_drv_next     = pcs_pkg::DRV_STOP;
        conv_on_next       = 1'b0;
        pulse_next         = 1'b0;
        empty_mark_next    = 1'b0;
        phase_next         = pcs_pkg::PH_IDLE;
        sub_step_next      = pcs_pkg::SUB_CLOSE;
        ms_timer_next      = 16'd0;
        pulse_counter_next = 16'd0;
        left_done_next     = 1'b0;
        right_done_next    = 1'b0;
      end else begin
        speed_next = in_data.rx_byte;
      end
    end else begin
      // millisecond tick
      case (phase)
        pcs_pkg::PH_IDLE: begin
          go_start = run_flag;
        end
        pcs_pkg::PH_VERT: begin
          ms_timer_next = timer_hit ? 16'd0 : timer_inc;
          if (sub_step == pcs_pkg::SUB_CLOSE) begin
            if (timer_hit) begin
              if (!left_done && in_data.vert_left_limit) begin
                left_done_next = 1'b1;
                left_drv_next  = pcs_pkg::DRV_STOP;
              end
              if (!right_done && in_data.vert_right_limit) begin
                right_done_next = 1'b1;
                right_drv_next  = pcs_pkg::DRV_STOP;
              end
              if (left_done_next && right_done_next) begin
                sub_step_next = pcs_pkg::SUB_DWELL;
                ms_timer_next = 16'd0;
              end
            end
          end else if (sub_step == pcs_pkg::SUB_DWELL) begin
            if (timer_hit) begin
              sub_step_next  = pcs_pkg::SUB_OPEN;
              left_drv_next  = pcs_pkg::DRV_OPEN;
              right_drv_next = pcs_pkg::DRV_OPEN;
            end
          end else if (timer_hit) begin
            left_drv_next  = pcs_pkg::DRV_STOP;
            right_drv_next = pcs_pkg::DRV_STOP;
            go_film        = 1'b1;
          end
        end
        pcs_pkg::PH_FILM: begin
          ms_timer_next = timer_hit ? 16'd0 : timer_inc;
          if (timer_hit) begin
            if (sub_step == pcs_pkg::SUB_CLOSE) begin
              sub_step_next = pcs_pkg::SUB_DWELL;
              pulse_next    = 1'b0;
            end else begin
              pulse_counter_next = pc_inc;
              if (pc_inc >= film_pulses) begin
                go_conv = 1'b1;
              end else begin
                sub_step_next = pcs_pkg::SUB_CLOSE;
                pulse_next    = 1'b1;
              end
            end
          end
        end
        pcs_pkg::PH_CONV: begin
          ms_timer_next = timer_hit ? 16'd0 : timer_inc;
          if (timer_hit && (speed == 8'd0 || in_data.object_seen)) begin
            conv_on_next = 1'b0;
            go_horiz     = 1'b1;
          end
        end
        pcs_pkg::PH_HORIZ: begin
          ms_timer_next = timer_hit ? 16'd0 : timer_inc;
          if (sub_step == pcs_pkg::SUB_CLOSE) begin
            if (timer_hit && in_data.horiz_limit) begin
              horiz_drv_next = pcs_pkg::DRV_STOP;
              sub_step_next  = pcs_pkg::SUB_DWELL;
            end
          end else if (sub_step == pcs_pkg::SUB_DWELL) begin
            if (timer_hit) begin
              sub_step_next  = pcs_pkg::SUB_OPEN;
              horiz_drv_next = pcs_pkg::DRV_OPEN;
            end
          end else if (timer_hit) begin
            horiz_drv_next = pcs_pkg::DRV_STOP;
            if (!empty_mark) count_next = count + 32'd1;
            go_start = 1'b1;
          end
        end
        default: begin
          phase_next    = pcs_pkg::PH_IDLE;
          sub_step_next = pcs_pkg::SUB_CLOSE;
          ms_timer_next = 16'd0;
        end
      endcase
    end

    // new cycle: take the pending no-product mark and close the vertical jaws
    if (go_start) begin
      empty_mark_next = empty_flag;
      empty_flag_next = 1'b0;
      phase_next      = pcs_pkg::PH_VERT;
      sub_step_next   = pcs_pkg::SUB_CLOSE;
      ms_timer_next   = 16'd0;
      left_done_next  = 1'b0;
      right_done_next = 1'b0;
      left_drv_next   = pcs_pkg::DRV_CLOSE;
      right_drv_next  = pcs_pkg::DRV_CLOSE;
    end

    // phase entry chain: film pull, then conveyor, then horizontal seal
    if (go_film) begin
      pulse_counter_next = 16'd0;
      if (film_pulses == 16'd0) begin
        go_conv = 1'b1;
      end else begin
        phase_next    = pcs_pkg::PH_FILM;
        sub_step_next = pcs_pkg::SUB_CLOSE;
        ms_timer_next = 16'd0;
        pulse_next    = 1'b1;
      end
    end
    if (go_conv) begin
      if (empty_mark || speed == 8'd0) begin
        go_horiz = 1'b1;
      end else begin
        phase_next    = pcs_pkg::PH_CONV;
        sub_step_next = pcs_pkg::SUB_CLOSE;
        ms_timer_next = 16'd0;
        conv_on_next  = 1'b1;
      end
    end
    if (go_horiz) begin
      phase_next     = pcs_pkg::PH_HORIZ;
      sub_step_next  = pcs_pkg::SUB_CLOSE;
      ms_timer_next  = 16'd0;
      horiz_drv_next = pcs_pkg::DRV_CLOSE;
    end
  end

  // result beat from the updated state
  always_comb begin
    result.running          = run_flag_next;
    result.phase            = phase_next;
    result.vert_left_drive  = left_drv_next;
    result.vert_right_drive = right_drv_next;
    result.horiz_drive      = horiz_drv_next;
    result.conveyor_on      = conv_on_next;
    result.conveyor_speed   = speed_next;
    result.stepper_pulse    = pulse_next;
    result.product_count    = count_next;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag      <= 1'b0;
      empty_flag    <= 1'b0;
      empty_mark    <= 1'b0;
      phase         <= pcs_pkg::PH_IDLE;
      sub_step      <= pcs_pkg::SUB_CLOSE;
      ms_timer      <= 16'd0;
      pulse_counter <= 16'd0;
      left_done     <= 1'b0;
      right_done    <= 1'b0;
      speed         <= 8'd0;
      count         <= 32'd0;
      left_drv      <= pcs_pkg::DRV_STOP;
      right_drv     <= pcs_pkg::DRV_STOP;
      horiz_drv     <= pcs_pkg::DRV_STOP;
      conv_on       <= 1'b0;
      pulse         <= 1'b0;
    end else if (in_take) begin
      run_flag      <= run_flag_next;
      empty_flag    <= empty_flag_next;
      empty_mark    <= empty_mark_next;
      phase         <= phase_next;
      sub_step      <= sub_step_next;
      ms_timer      <= ms_timer_next;
      pulse_counter <= pulse_counter_next;
      left_done     <= left_done_next;
      right_done    <= right_done_next;
      speed         <= speed_next;
      count         <= count_next;
      left_drv      <= left_drv_next;
      right_drv     <= right_drv_next;
      horiz_drv     <= horiz_drv_next;
      conv_on       <= conv_on_next;
      pulse         <= pulse_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // a cycle only runs while the machine is running
  assert property (@(posedge clk) disable iff (rst)
    (phase != pcs_pkg::PH_IDLE) |-> run_flag)
    else $error("cycle active while stopped");

  // conveyor runs only in the conveyor phase
  assert property (@(posedge clk) disable iff (rst)
    conv_on |-> (phase == pcs_pkg::PH_CONV))
    else $error("conveyor on outside conveyor phase");

  // stepper pulse high only during film pull
  assert property (@(posedge clk) disable iff (rst)
    pulse |-> (phase == pcs_pkg::PH_FILM))
    else $error("stepper pulse outside film pull");

  // horizontal motor moves only in the horizontal seal
  assert property (@(posedge clk) disable iff (rst)
    (horiz_drv != pcs_pkg::DRV_STOP) |-> (phase == pcs_pkg::PH_HORIZ))
    else $error("horizontal motor active outside horizontal seal");

  // product count advances by one at most per beat
  assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> (count == $past(count) + 32'd1))
    else $error("product count jumped");
`endif

endmodule
